// ----- rtl/sga_pkg.sv -----
// ----------------------------------------------------------------------------
// sga_pkg: shared types and helpers
// types, constants and saturating arithmetic for the semiglobal aligner
// ----------------------------------------------------------------------------
package sga_pkg;

    localparam int unsigned QUERY_MAX_DEF = 64;
    localparam int unsigned SCORE_BITS    = 16;
    localparam int unsigned SYM_BITS      = 16;
    localparam int unsigned POS_BITS      = 6;
    localparam int unsigned LEN_BITS      = 7;
    localparam int unsigned CFG_ADDR_BITS = 3;
    localparam int unsigned WIDE_BITS     = 50;

    localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = 16'sh7fff;
    localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = 16'sh8000;

    localparam logic signed [SCORE_BITS-1:0] RST_MATCH      = 16'sd1;
    localparam logic signed [SCORE_BITS-1:0] RST_MISMATCH   = -16'sd1;
    localparam logic signed [SCORE_BITS-1:0] RST_GAP_OPEN   = -16'sd2;
    localparam logic signed [SCORE_BITS-1:0] RST_GAP_EXTEND = -16'sd1;
    localparam logic [LEN_BITS-1:0]          RST_QUERY_LEN  = 7'd64;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_MATCH      = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MISMATCH   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_GAP_OPEN   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_GAP_EXTEND = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_QUERY_LEN  = 3'd4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DB   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LAUNCH,
        S_RUN,
        S_OUT,
        S_CLR
    } t_state;

    typedef struct packed {
        logic signed [SCORE_BITS-1:0] match_score;
        logic signed [SCORE_BITS-1:0] mismatch_score;
        logic signed [SCORE_BITS-1:0] gap_open;
        logic signed [SCORE_BITS-1:0] gap_extend;
    } t_scores;

    typedef struct packed {
        logic                         valid;
        logic                         fresh;
        logic [SYM_BITS-1:0]          sym;
        logic signed [SCORE_BITS-1:0] diag;
        logic signed [SCORE_BITS-1:0] f;
    } t_token;

    typedef struct packed {
        logic                load;
        logic [POS_BITS-1:0] load_pos;
        logic [SYM_BITS-1:0] load_sym;
        logic                shift;
        logic                clear;
    } t_cell_ctl;

    function automatic logic signed [SCORE_BITS-1:0] sat_add(
        input logic signed [SCORE_BITS-1:0] a,
        input logic signed [SCORE_BITS-1:0] b
    );
        logic signed [SCORE_BITS:0] s;
        s = {a[SCORE_BITS-1], a} + {b[SCORE_BITS-1], b};
        if (s > 17'sd32767) begin
            return SCORE_MAX;
        end else if (s < -17'sd32768) begin
            return SCORE_MIN;
        end
        return s[SCORE_BITS-1:0];
    endfunction

    function automatic logic signed [SCORE_BITS-1:0] sat_wide(
        input logic signed [WIDE_BITS-1:0] v
    );
        if (v > 50'sd32767) begin
            return SCORE_MAX;
        end else if (v < -50'sd32768) begin
            return SCORE_MIN;
        end
        return v[SCORE_BITS-1:0];
    endfunction

    function automatic logic signed [SCORE_BITS-1:0] smax(
        input logic signed [SCORE_BITS-1:0] a,
        input logic signed [SCORE_BITS-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- rtl/sga_cell.sv -----
// ----------------------------------------------------------------------------
// sga_cell: one query position of the alignment row
// holds a query symbol and its H/E pair, updates them as a column passes
// ----------------------------------------------------------------------------
module sga_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [sga_pkg::LEN_BITS-1:0]      i_len,
    input  sga_pkg::t_scores                  i_scores,
    input  sga_pkg::t_cell_ctl                i_ctl,
    input  sga_pkg::t_token                   i_tok,
    output sga_pkg::t_token                   o_tok,
    input  logic signed [sga_pkg::SCORE_BITS-1:0] i_h_next,
    output logic signed [sga_pkg::SCORE_BITS-1:0] o_h
);

    logic [sga_pkg::SYM_BITS-1:0]          r_q;
    logic signed [sga_pkg::SCORE_BITS-1:0] r_h;
    logic signed [sga_pkg::SCORE_BITS-1:0] r_e;
    sga_pkg::t_token                       r_tok;
    logic                                  r_tok_valid;

    logic                                  w_active;
    logic signed [sga_pkg::SCORE_BITS-1:0] w_hprev;
    logic signed [sga_pkg::SCORE_BITS-1:0] w_eprev;
    logic signed [sga_pkg::SCORE_BITS-1:0] w_sub;
    logic signed [sga_pkg::SCORE_BITS-1:0] n_h;
    logic signed [sga_pkg::SCORE_BITS-1:0] w_hg;
    logic signed [sga_pkg::SCORE_BITS-1:0] n_e;
    logic signed [sga_pkg::SCORE_BITS-1:0] w_f;

    assign w_active = (sga_pkg::LEN_BITS'(IDX) < i_len);

    always_comb begin
        w_hprev = i_tok.fresh ? '0 : r_h;
        w_eprev = i_tok.fresh ? i_scores.gap_open : r_e;
        w_sub   = (r_q == i_tok.sym) ? i_scores.match_score : i_scores.mismatch_score;
        n_h     = sga_pkg::smax(sga_pkg::smax(sga_pkg::sat_add(i_tok.diag, w_sub), w_eprev),
                                i_tok.f);
        w_hg    = sga_pkg::sat_add(n_h, i_scores.gap_open);
        n_e     = sga_pkg::smax(sga_pkg::sat_add(w_eprev, i_scores.gap_extend), w_hg);
        w_f     = sga_pkg::smax(sga_pkg::sat_add(i_tok.f, i_scores.gap_extend), w_hg);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_ctl.load_pos == sga_pkg::POS_BITS'(IDX))) begin
            r_q <= i_ctl.load_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= '0;
            r_e <= sga_pkg::RST_GAP_OPEN;
        end else if (i_ctl.clear) begin
            r_h <= '0;
            r_e <= i_scores.gap_open;
        end else if (i_ctl.shift) begin
            r_h <= i_h_next;
        end else if (i_tok.valid && w_active) begin
            r_h <= n_h;
            r_e <= n_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok.valid <= 1'b0;
        r_tok.fresh <= i_tok.fresh;
        r_tok.sym   <= i_tok.sym;
        r_tok.diag  <= w_hprev;
        r_tok.f     <= w_f;
    end

    always_comb begin
        o_tok       = r_tok;
        o_tok.valid = r_tok_valid;
    end

    assign o_h = r_h;

endmodule

// ----- rtl/semiglobal_affine_alignment_unit.sv -----
// ----------------------------------------------------------------------------
// semiglobal_affine_alignment_unit: affine-gap semiglobal aligner
// row of query cells swept by one database column at a time
// ----------------------------------------------------------------------------
// requests enter on the s_axis group: tuser is the command (load a query
// symbol or process a database symbol), tdata holds symbol and query
// position, tlast marks the final database symbol of an alignment.
// a database symbol holds the input through the boundary product (S_MUL),
// the launch of the column wave (S_LAUNCH) and the walk of the wave along
// the cell row (S_RUN), one cell per cycle up to the query length.
// after the final symbol the column is shifted out of the row on m_axis,
// one score per cycle while the receiver takes it (tlast on the last
// position), then the S_CLR state clears the row; a stalled receiver holds the
// output register and freezes the shift.
// the config port writes scores and query length by index; write it idle.
// reset restores default scores, clears the columns and the output.
// ----------------------------------------------------------------------------
module semiglobal_affine_alignment_unit #(
    parameter int unsigned QUERY_MAX = sga_pkg::QUERY_MAX_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [sga_pkg::CFG_ADDR_BITS-1:0]      i_cfg_addr,
    input  logic [sga_pkg::SCORE_BITS-1:0]         i_cfg_wdata,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [23:0]                            i_s_axis_tdata, // symbol, query_position
    input  logic                                   i_s_axis_tuser, // cmd
    input  logic                                   i_s_axis_tlast,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [23:0]                            o_m_axis_tdata, // score, result_position
    output logic                                   o_m_axis_tlast
);

    localparam int unsigned SB = sga_pkg::SCORE_BITS;
    localparam int unsigned WB = sga_pkg::WIDE_BITS;

    sga_pkg::t_state                   r_state;
    sga_pkg::t_state                   n_state;
    sga_pkg::t_scores                  r_scores;
    logic [sga_pkg::LEN_BITS-1:0]      r_query_length;
    logic [sga_pkg::LEN_BITS-1:0]      w_len;

    logic [sga_pkg::SYM_BITS-1:0]      r_sym;
    logic                              r_last;
    logic                              r_fresh;
    logic [31:0]                       r_colcnt;
    logic [31:0]                       r_j_m1;
    logic signed [48:0]                r_prod;
    logic signed [48:0]                w_prod;
    logic [sga_pkg::LEN_BITS-1:0]      r_cnt;
    logic [sga_pkg::POS_BITS-1:0]      r_opos;

    logic                              r_out_valid;
    logic signed [SB-1:0]              r_out_score;
    logic [sga_pkg::POS_BITS-1:0]      r_out_pos;
    logic                              r_out_last;

    logic                              w_accept;
    logic                              w_emit;
    logic                              w_emit_last;
    logic signed [WB-1:0]              w_diag_w;
    logic signed [WB-1:0]              w_f_w;
    sga_pkg::t_token                   w_launch;
    sga_pkg::t_cell_ctl                w_ctl;

    sga_pkg::t_token                   w_tok [QUERY_MAX+1];
    logic signed [SB-1:0]              w_h   [QUERY_MAX+1];

    always_comb begin
        if (r_query_length == '0) begin
            w_len = sga_pkg::LEN_BITS'(1);
        end else if (r_query_length > sga_pkg::LEN_BITS'(QUERY_MAX)) begin
            w_len = sga_pkg::LEN_BITS'(QUERY_MAX);
        end else begin
            w_len = r_query_length;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scores.match_score    <= sga_pkg::RST_MATCH;
            r_scores.mismatch_score <= sga_pkg::RST_MISMATCH;
            r_scores.gap_open       <= sga_pkg::RST_GAP_OPEN;
            r_scores.gap_extend     <= sga_pkg::RST_GAP_EXTEND;
            r_query_length          <= sga_pkg::RST_QUERY_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sga_pkg::CFG_MATCH:      r_scores.match_score    <= i_cfg_wdata;
                sga_pkg::CFG_MISMATCH:   r_scores.mismatch_score <= i_cfg_wdata;
                sga_pkg::CFG_GAP_OPEN:   r_scores.gap_open       <= i_cfg_wdata;
                sga_pkg::CFG_GAP_EXTEND: r_scores.gap_extend     <= i_cfg_wdata;
                sga_pkg::CFG_QUERY_LEN:  r_query_length <= i_cfg_wdata[sga_pkg::LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == sga_pkg::S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_emit          = (r_state == sga_pkg::S_OUT) && (!r_out_valid || i_m_axis_tready);
    assign w_emit_last     = (sga_pkg::LEN_BITS'(r_opos) + sga_pkg::LEN_BITS'(1)) == w_len;

    assign w_prod   = $signed({1'b0, r_j_m1}) * r_scores.gap_extend;
    assign w_diag_w = WB'(r_scores.gap_open) + WB'(r_prod);
    assign w_f_w    = WB'(r_scores.gap_open) + WB'(r_scores.gap_open) + WB'(r_prod)
                      + WB'(r_scores.gap_extend);

    always_comb begin
        n_state        = r_state;
        w_launch       = '0;
        w_launch.fresh = r_fresh;
        w_launch.sym   = r_sym;
        w_launch.diag  = r_fresh ? '0 : sga_pkg::sat_wide(w_diag_w);
        w_launch.f     = r_fresh ? sga_pkg::sat_add(r_scores.gap_open, r_scores.gap_open)
                                 : sga_pkg::sat_wide(w_f_w);
        w_ctl          = '0;
        w_ctl.load_pos = i_s_axis_tdata[21:16];
        w_ctl.load_sym = i_s_axis_tdata[15:0];
        unique case (r_state)
            sga_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_s_axis_tuser == sga_pkg::CMD_DB) begin
                        n_state = sga_pkg::S_MUL;
                    end else begin
                        w_ctl.load = 1'b1;
                    end
                end
            end
            sga_pkg::S_MUL: begin
                n_state = sga_pkg::S_LAUNCH;
            end
            sga_pkg::S_LAUNCH: begin
                w_launch.valid = 1'b1;
                n_state        = sga_pkg::S_RUN;
            end
            sga_pkg::S_RUN: begin
                if (r_cnt >= w_len - sga_pkg::LEN_BITS'(1)) begin
                    n_state = r_last ? sga_pkg::S_OUT : sga_pkg::S_IDLE;
                end
            end
            sga_pkg::S_OUT: begin
                w_ctl.shift = w_emit;
                if (w_emit && w_emit_last) begin
                    n_state = sga_pkg::S_CLR;
                end
            end
            sga_pkg::S_CLR: begin
                w_ctl.clear = 1'b1;
                n_state     = sga_pkg::S_IDLE;
            end
            default: n_state = sga_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sga_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colcnt <= '0;
            r_cnt    <= '0;
            r_opos   <= '0;
        end else begin
            if (r_state == sga_pkg::S_LAUNCH) begin
                r_cnt <= sga_pkg::LEN_BITS'(1);
                if (r_colcnt != '1) begin
                    r_colcnt <= r_colcnt + 32'd1;
                end
            end else if (r_state == sga_pkg::S_RUN) begin
                r_cnt <= r_cnt + sga_pkg::LEN_BITS'(1);
                r_opos <= '0;
            end
            if (w_emit) begin
                r_opos <= r_opos + sga_pkg::POS_BITS'(1);
            end
            if (r_state == sga_pkg::S_CLR) begin
                r_colcnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sym   <= i_s_axis_tdata[15:0];
            r_last  <= i_s_axis_tlast;
            r_fresh <= (r_colcnt == '0);
            r_j_m1  <= r_colcnt - 32'd1;
        end
        if (r_state == sga_pkg::S_MUL) begin
            r_prod <= w_prod;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_score <= w_h[0];
            r_out_pos   <= r_opos;
            r_out_last  <= w_emit_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_pos, r_out_score};
    assign o_m_axis_tlast  = r_out_last;

    // cell row
    assign w_tok[0]         = w_launch;
    assign w_h[QUERY_MAX]   = '0;

    for (genvar g = 0; g < QUERY_MAX; g++) begin : g_cell
        sga_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_len    (w_len),
            .i_scores (r_scores),
            .i_ctl    (w_ctl),
            .i_tok    (w_tok[g]),
            .o_tok    (w_tok[g+1]),
            .i_h_next (w_h[g+1]),
            .o_h      (w_h[g])
        );
    end

    a_db_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_s_axis_tuser == sga_pkg::CMD_DB) |=> r_state == sga_pkg::S_MUL)
        else $error("database request did not start a column");

    a_no_wave_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sga_pkg::S_OUT) |-> !w_tok[0].valid)
        else $error("column launched while draining");

    a_clr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sga_pkg::S_CLR) |=> (r_colcnt == '0) && (r_state == sga_pkg::S_IDLE))
        else $error("clear did not restart the column count");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && w_emit_last |=> o_m_axis_tlast && o_m_axis_tvalid)
        else $error("last position not flagged");

endmodule
